// ===== rtl/u8r_pkg.sv =====
// Package for the UTF-8 encoder byte ring: sizes, index helpers, state codes
// and the code point encoder. No dependencies.
package u8r_pkg;

  // ring and take sizes
  localparam int RING_DEPTH = 1024;
  localparam int TAKE_MAX   = 16;
  localparam int IDX_WRAP   = 2 * RING_DEPTH;
  localparam int IDX_W      = $clog2(IDX_WRAP);
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(TAKE_MAX + 1);

  // item function codes
  localparam logic FUNC_EMIT = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  // encoding constants
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] SURR_LO     = 21'h00D800;
  localparam logic [20:0] SURR_HI     = 21'h00DFFF;
  localparam logic [20:0] CP_REPLACE  = 21'h00FFFD;
  localparam logic [20:0] LIM_1BYTE   = 21'h000080;
  localparam logic [20:0] LIM_2BYTE   = 21'h000800;
  localparam logic [20:0] LIM_3BYTE   = 21'h010000;
  localparam logic [7:0]  LEAD_2      = 8'hC0;
  localparam logic [7:0]  LEAD_3      = 8'hE0;
  localparam logic [7:0]  LEAD_4      = 8'hF0;
  localparam logic [7:0]  CONT_MARK   = 8'h80;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_TAKE_RD,
    ST_TAKE_OUT
  } state_t;

  // encoded code point: bytes in send order and index of the final byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      top;
  } enc_t;

  // advance an index modulo twice the ring depth
  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    r = (i == IDX_W'(IDX_WRAP - 1)) ? '0 : i + IDX_W'(1);
    return r;
  endfunction

  // map an index to its ring slot
  function automatic logic [ADDR_W-1:0] idx_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] s;
    s = (i >= IDX_W'(RING_DEPTH)) ? i - IDX_W'(RING_DEPTH) : i;
    return s[ADDR_W-1:0];
  endfunction

  // bytes held between read and write index
  function automatic logic [IDX_W-1:0] fill_of(input logic [IDX_W-1:0] w,
                                               input logic [IDX_W-1:0] r);
    logic [IDX_W-1:0] f;
    f = (w >= r) ? w - r : w - r + IDX_W'(IDX_WRAP);
    return f;
  endfunction

  // encode one code point as UTF-8, invalid scalars become the replacement
  function automatic enc_t encode(input logic [20:0] cp_in);
    enc_t        e;
    logic [20:0] c;
    c = cp_in;
    if (c > CP_MAX || (c >= SURR_LO && c <= SURR_HI)) begin
      c = CP_REPLACE;
    end
    e.bytes = '0;
    if (c < LIM_1BYTE) begin
      e.bytes[0] = {1'b0, c[6:0]};
      e.top      = 2'd0;
    end else if (c < LIM_2BYTE) begin
      e.bytes[0] = LEAD_2 | {3'b000, c[10:6]};
      e.bytes[1] = CONT_MARK | {2'b00, c[5:0]};
      e.top      = 2'd1;
    end else if (c < LIM_3BYTE) begin
      e.bytes[0] = LEAD_3 | {4'b0000, c[15:12]};
      e.bytes[1] = CONT_MARK | {2'b00, c[11:6]};
      e.bytes[2] = CONT_MARK | {2'b00, c[5:0]};
      e.top      = 2'd2;
    end else begin
      e.bytes[0] = LEAD_4 | {5'b00000, c[20:18]};
      e.bytes[1] = CONT_MARK | {2'b00, c[17:12]};
      e.bytes[2] = CONT_MARK | {2'b00, c[11:6]};
      e.bytes[3] = CONT_MARK | {2'b00, c[5:0]};
      e.top      = 2'd3;
    end
    return e;
  endfunction

endpackage

// ===== rtl/u8r_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module u8r_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, or read into the output register; rdata holds otherwise
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/utf8_encode_byte_ring.sv =====
// UTF-8 encoder feeding a byte ring of RING_DEPTH bytes held in one single-port
// RAM. An emit word encodes its code point (invalid scalars become U+FFFD) and
// writes 1 to 4 bytes, one per cycle through the RAM port, dropping bytes that
// find the ring full. A take word returns up to take_count bytes (capped at
// TAKE_MAX), oldest first, the final one marked by last; each byte is read from
// the RAM, then loaded into the output register once that register is free. A
// take on an empty ring returns one word with byte_valid low. The input is
// taken only while no word is in progress and the output register is free.
// The ring contents are not cleared at reset; only written bytes are ever read.
// Depends on u8r_pkg and u8r_ram.
module utf8_encode_byte_ring
  import u8r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [20:0] code_point,
  input  logic [4:0]  take_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        last
);

  state_t            state, state_next;
  logic [IDX_W-1:0]  wr_index, wr_index_next;
  logic [IDX_W-1:0]  rd_index, rd_index_next;
  enc_t              enc, enc_next;
  logic [1:0]        byte_sel, byte_sel_next;
  logic [CNT_W-1:0]  remain, remain_next;
  logic              out_valid_next;
  logic [7:0]        data_byte_next;
  logic              byte_valid_next;
  logic              last_next;

  logic              accept;
  logic              out_free;
  logic [IDX_W-1:0]  fill;
  logic [IDX_W-1:0]  rd_inc;
  logic [CNT_W-1:0]  want;
  logic              final_byte;
  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  u8r_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // handshake and shared terms
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = !(state == ST_IDLE && out_free);
  assign accept     = in_valid && !in_stall;
  assign fill       = fill_of(wr_index, rd_index);
  assign rd_inc     = idx_next(rd_index);
  assign want       = (int'(take_count) > TAKE_MAX) ? CNT_W'(TAKE_MAX) : CNT_W'(take_count);
  assign final_byte = (remain == CNT_W'(1)) || (rd_inc == wr_index);

  // sequencer: next state, index updates, RAM access, output load
  always_comb begin
    state_next      = state;
    wr_index_next   = wr_index;
    rd_index_next   = rd_index;
    enc_next        = enc;
    byte_sel_next   = byte_sel;
    remain_next     = remain;
    out_valid_next  = out_valid;
    data_byte_next  = data_byte;
    byte_valid_next = byte_valid;
    last_next       = last;
    ram_en          = 1'b0;
    ram_we          = 1'b0;
    ram_addr        = idx_slot(wr_index);
    ram_wdata       = enc.bytes[byte_sel];

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_EMIT) begin
            enc_next      = encode(code_point);
            byte_sel_next = 2'd0;
            state_next    = ST_EMIT;
          end else if (fill == '0) begin
            // empty ring: one word marked not valid, indices back to zero
            out_valid_next  = 1'b1;
            data_byte_next  = 8'h00;
            byte_valid_next = 1'b0;
            last_next       = 1'b1;
            rd_index_next   = '0;
            wr_index_next   = '0;
          end else if (want != '0) begin
            remain_next = want;
            state_next  = ST_TAKE_RD;
          end
        end
      end
      ST_EMIT: begin
        // write one byte per cycle, drop it when the ring is full
        if (fill < IDX_W'(RING_DEPTH)) begin
          ram_en        = 1'b1;
          ram_we        = 1'b1;
          wr_index_next = idx_next(wr_index);
        end
        byte_sel_next = byte_sel + 2'd1;
        if (byte_sel == enc.top) begin
          state_next = ST_IDLE;
        end
      end
      ST_TAKE_RD: begin
        ram_en     = 1'b1;
        ram_addr   = idx_slot(rd_index);
        state_next = ST_TAKE_OUT;
      end
      ST_TAKE_OUT: begin
        // load the byte once the output register is free
        if (out_free) begin
          out_valid_next  = 1'b1;
          data_byte_next  = ram_rdata;
          byte_valid_next = 1'b1;
          last_next       = final_byte;
          rd_index_next   = rd_inc;
          remain_next     = remain - CNT_W'(1);
          if (final_byte) begin
            state_next = ST_IDLE;
            if (rd_inc == wr_index) begin
              rd_index_next = '0;
              wr_index_next = '0;
            end
          end else begin
            state_next = ST_TAKE_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_index  <= '0;
      rd_index  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr_index  <= wr_index_next;
      rd_index  <= rd_index_next;
      out_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    enc        <= enc_next;
    byte_sel   <= byte_sel_next;
    remain     <= remain_next;
    data_byte  <= data_byte_next;
    byte_valid <= byte_valid_next;
    last       <= last_next;
  end

endmodule
